>>> hw/rtl/twte_pkg.sv
package twte_pkg;

    // Fixed field widths of the item and result channels.
    localparam int CITY_W = 8;
    localparam int OP_W   = 2;
    localparam int SUM_W  = 32;
    localparam int VIOL_W = 9;

    // Operation codes carried by an input item.
    localparam logic [OP_W-1:0] OP_TRAVEL = 2'd0;
    localparam logic [OP_W-1:0] OP_WINDOW = 2'd1;
    localparam logic [OP_W-1:0] OP_TOUR   = 2'd2;

    // Saturation limits of the accumulators.
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [VIOL_W-1:0] VIOL_MAX = '1;

    // Evaluation sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_CHECK,
        ST_RET_ADD,
        ST_RET_CHECK
    } t_state;

    // Write and read strobes for the two table memories.
    typedef struct packed {
        logic travel_we;
        logic travel_re;
        logic window_we;
        logic window_re;
    } t_mem_ctl;

endpackage

>>> hw/rtl/time_window_tour_evaluator.sv
// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_stall  i_operation, i_city_a, i_city_b, i_travel_time,
//                                               i_window_open, i_window_close, i_last_city
// output    out        o_out_valid / i_out_stall o_tour_duration, o_violation_count
//
// A load item is written to its table on its transfer. A tour city first reads the travel
// and window tables, then does the leg addition; its window check overlaps the transfer
// of the next item. The closing city adds a return leg, which needs a second pass through
// the single read port of each table; its return check repeats while the output register
// holds a stalled result. A finished result waits in the output register while new
// items are taken. Reset clears only control state; the tables are not cleared.
module time_window_tour_evaluator #(
    parameter int MAX_CITIES = 256,
    parameter int DIST_BITS  = 16,
    parameter int TIME_BITS  = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [twte_pkg::OP_W-1:0]       i_operation,
    input  logic [twte_pkg::CITY_W-1:0]     i_city_a,
    input  logic [twte_pkg::CITY_W-1:0]     i_city_b,
    input  logic [DIST_BITS-1:0]            i_travel_time,
    input  logic [TIME_BITS-1:0]            i_window_open,
    input  logic [TIME_BITS-1:0]            i_window_close,
    input  logic                            i_last_city,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [twte_pkg::SUM_W-1:0]      o_tour_duration,
    output logic [twte_pkg::VIOL_W-1:0]     o_violation_count
);

    localparam int CW        = $clog2(MAX_CITIES);
    localparam int LutDepth  = 1 << twte_pkg::CITY_W;

    logic [CW-1:0]                  w_city_lut [LutDepth];
    logic [CW-1:0]                  w_city_a;
    logic [CW-1:0]                  w_city_b;
    twte_pkg::t_mem_ctl             w_mem_ctl;
    logic [2*CW-1:0]                w_travel_waddr;
    logic [DIST_BITS-1:0]           w_travel_wdata;
    logic [2*CW-1:0]                w_travel_raddr;
    logic [CW-1:0]                  w_window_waddr;
    logic [TIME_BITS-1:0]           w_open_wdata;
    logic [TIME_BITS-1:0]           w_close_wdata;
    logic [CW-1:0]                  w_window_raddr;
    logic [DIST_BITS-1:0]           w_travel_rdata;
    logic [TIME_BITS-1:0]           w_open_rdata;
    logic [TIME_BITS-1:0]           w_close_rdata;
    logic                           w_res_free;
    logic                           w_res_load;
    logic [twte_pkg::SUM_W-1:0]     w_res_duration;
    logic [twte_pkg::VIOL_W-1:0]    w_res_violations;
    logic                           r_out_valid;
    logic [twte_pkg::SUM_W-1:0]     r_duration;
    logic [twte_pkg::VIOL_W-1:0]    r_violations;

    // Constant table that folds a city number into the table range.
    for (genvar g = 0; g < LutDepth; g++) begin : g_city_lut
        assign w_city_lut[g] = CW'(g % MAX_CITIES);
    end

    assign w_city_a = w_city_lut[i_city_a];
    assign w_city_b = w_city_lut[i_city_b];

    twte_eval #(
        .CW        (CW),
        .DIST_BITS (DIST_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_eval (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_stall          (o_in_stall),
        .i_operation      (i_operation),
        .i_city_a         (w_city_a),
        .i_city_b         (w_city_b),
        .i_travel_time    (i_travel_time),
        .i_window_open    (i_window_open),
        .i_window_close   (i_window_close),
        .i_last_city      (i_last_city),
        .o_mem_ctl        (w_mem_ctl),
        .o_travel_waddr   (w_travel_waddr),
        .o_travel_wdata   (w_travel_wdata),
        .o_travel_raddr   (w_travel_raddr),
        .o_window_waddr   (w_window_waddr),
        .o_open_wdata     (w_open_wdata),
        .o_close_wdata    (w_close_wdata),
        .o_window_raddr   (w_window_raddr),
        .i_travel_rdata   (w_travel_rdata),
        .i_open_rdata     (w_open_rdata),
        .i_close_rdata    (w_close_rdata),
        .i_res_free       (w_res_free),
        .o_res_load       (w_res_load),
        .o_res_duration   (w_res_duration),
        .o_res_violations (w_res_violations)
    );

    twte_tables #(
        .CW        (CW),
        .DIST_BITS (DIST_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_tables (
        .i_clk          (i_clk),
        .i_ctl          (w_mem_ctl),
        .i_travel_waddr (w_travel_waddr),
        .i_travel_wdata (w_travel_wdata),
        .i_travel_raddr (w_travel_raddr),
        .i_window_waddr (w_window_waddr),
        .i_open_wdata   (w_open_wdata),
        .i_close_wdata  (w_close_wdata),
        .i_window_raddr (w_window_raddr),
        .o_travel_rdata (w_travel_rdata),
        .o_open_rdata   (w_open_rdata),
        .o_close_rdata  (w_close_rdata)
    );

    // The output register can take a result when empty or when its transfer completes.
    assign w_res_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_duration   <= w_res_duration;
            r_violations <= w_res_violations;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_tour_duration   = r_duration;
    assign o_violation_count = r_violations;

endmodule

>>> hw/rtl/twte_tables.sv
module twte_tables #(
    parameter int CW        = 8,
    parameter int DIST_BITS = 16,
    parameter int TIME_BITS = 24
) (
    input  logic                 i_clk,
    input  twte_pkg::t_mem_ctl   i_ctl,
    input  logic [2*CW-1:0]      i_travel_waddr,
    input  logic [DIST_BITS-1:0] i_travel_wdata,
    input  logic [2*CW-1:0]      i_travel_raddr,
    input  logic [CW-1:0]        i_window_waddr,
    input  logic [TIME_BITS-1:0] i_open_wdata,
    input  logic [TIME_BITS-1:0] i_close_wdata,
    input  logic [CW-1:0]        i_window_raddr,
    output logic [DIST_BITS-1:0] o_travel_rdata,
    output logic [TIME_BITS-1:0] o_open_rdata,
    output logic [TIME_BITS-1:0] o_close_rdata
);

    localparam int TravelDepth = 1 << (2 * CW);
    localparam int WindowDepth = 1 << CW;

    logic [DIST_BITS-1:0]   r_travel_mem [TravelDepth];
    logic [2*TIME_BITS-1:0] r_window_mem [WindowDepth];
    logic [DIST_BITS-1:0]   r_travel_rdata;
    logic [2*TIME_BITS-1:0] r_window_rdata;

    // Travel table: one write port, one read port, read data held until the next read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.travel_we) begin
            r_travel_mem[i_travel_waddr] <= i_travel_wdata;
        end
        if (i_ctl.travel_re) begin
            r_travel_rdata <= r_travel_mem[i_travel_raddr];
        end
    end

    // Window table holds the open time in the upper half and the close time in the lower.
    always_ff @(posedge i_clk) begin
        if (i_ctl.window_we) begin
            r_window_mem[i_window_waddr] <= {i_open_wdata, i_close_wdata};
        end
        if (i_ctl.window_re) begin
            r_window_rdata <= r_window_mem[i_window_raddr];
        end
    end

    assign o_travel_rdata = r_travel_rdata;
    assign o_open_rdata   = r_window_rdata[2*TIME_BITS-1:TIME_BITS];
    assign o_close_rdata  = r_window_rdata[TIME_BITS-1:0];

endmodule

>>> hw/rtl/twte_eval.sv
module twte_eval #(
    parameter int CW        = 8,
    parameter int DIST_BITS = 16,
    parameter int TIME_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input item, city numbers already reduced to the table range
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [twte_pkg::OP_W-1:0]       i_operation,
    input  logic [CW-1:0]                   i_city_a,
    input  logic [CW-1:0]                   i_city_b,
    input  logic [DIST_BITS-1:0]            i_travel_time,
    input  logic [TIME_BITS-1:0]            i_window_open,
    input  logic [TIME_BITS-1:0]            i_window_close,
    input  logic                            i_last_city,
    // Table memory access
    output twte_pkg::t_mem_ctl              o_mem_ctl,
    output logic [2*CW-1:0]                 o_travel_waddr,
    output logic [DIST_BITS-1:0]            o_travel_wdata,
    output logic [2*CW-1:0]                 o_travel_raddr,
    output logic [CW-1:0]                   o_window_waddr,
    output logic [TIME_BITS-1:0]            o_open_wdata,
    output logic [TIME_BITS-1:0]            o_close_wdata,
    output logic [CW-1:0]                   o_window_raddr,
    input  logic [DIST_BITS-1:0]            i_travel_rdata,
    input  logic [TIME_BITS-1:0]            i_open_rdata,
    input  logic [TIME_BITS-1:0]            i_close_rdata,
    // Result handoff to the output register
    input  logic                            i_res_free,
    output logic                            o_res_load,
    output logic [twte_pkg::SUM_W-1:0]      o_res_duration,
    output logic [twte_pkg::VIOL_W-1:0]     o_res_violations
);

    localparam int SW = twte_pkg::SUM_W;
    localparam int VW = twte_pkg::VIOL_W;

    twte_pkg::t_state r_state, n_state;

    // Tour bookkeeping seen by the accepting side
    logic          r_active, n_active;
    logic [CW-1:0] r_start_city, n_start_city;
    logic [CW-1:0] r_prev_city, n_prev_city;

    // Item under evaluation
    logic          r_city_first, n_city_first;
    logic          r_city_last, n_city_last;
    logic [CW-1:0] r_city, n_city;

    // Accumulators
    logic [SW-1:0] r_arrival, n_arrival;
    logic [SW-1:0] r_sum, n_sum;
    logic [VW-1:0] r_viol, n_viol;

    logic          w_can_take;
    logic          w_accept;
    logic          w_tour_accept;
    logic          w_return_read;
    logic [SW-1:0] w_leg;
    logic [SW-1:0] w_leg_arrival;
    logic [SW-1:0] w_leg_sum;
    logic [SW-1:0] w_open;
    logic [SW-1:0] w_close;
    logic [SW-1:0] w_chk_arrival;
    logic [VW-1:0] w_chk_viol;

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SW] ? twte_pkg::SUM_MAX : s[SW-1:0];
    endfunction

    // A new item is taken when idle or while the window check of a non-closing city runs.
    assign w_can_take    = (r_state == twte_pkg::ST_IDLE)
                        || (r_state == twte_pkg::ST_CHECK && !r_city_last);
    assign o_stall       = !w_can_take;
    assign w_accept      = i_valid && w_can_take;
    assign w_tour_accept = w_accept && (i_operation == twte_pkg::OP_TOUR);
    assign w_return_read = (r_state == twte_pkg::ST_CHECK) && r_city_last;

    // Table writes happen on load transfers; reads never fall in the same cycle.
    assign o_mem_ctl.travel_we = w_accept && (i_operation == twte_pkg::OP_TRAVEL);
    assign o_mem_ctl.window_we = w_accept && (i_operation == twte_pkg::OP_WINDOW);
    assign o_mem_ctl.travel_re = w_tour_accept || w_return_read;
    assign o_mem_ctl.window_re = w_tour_accept || w_return_read;
    assign o_travel_waddr      = {i_city_a, i_city_b};
    assign o_travel_wdata      = i_travel_time;
    assign o_window_waddr      = i_city_a;
    assign o_open_wdata        = i_window_open;
    assign o_close_wdata       = i_window_close;

    // The return leg reads from the closing city back to the start city.
    assign o_travel_raddr = w_return_read ? {r_city, r_start_city} : {r_prev_city, i_city_a};
    assign o_window_raddr = w_return_read ? r_start_city : i_city_a;

    // Leg addition on the freshly read travel time.
    assign w_leg         = SW'(i_travel_rdata);
    assign w_leg_arrival = sat_add(r_arrival, w_leg);
    assign w_leg_sum     = sat_add(r_sum, w_leg);

    // Window check: wait for an early arrival, count a late one.
    assign w_open  = SW'(i_open_rdata);
    assign w_close = SW'(i_close_rdata);
    always_comb begin
        w_chk_arrival = r_arrival;
        w_chk_viol    = r_viol;
        if (r_arrival < w_open) begin
            w_chk_arrival = w_open;
        end else if (r_arrival > w_close && r_viol != twte_pkg::VIOL_MAX) begin
            w_chk_viol = r_viol + VW'(1);
        end
    end

    // Tour bookkeeping follows the accepted tour items in order.
    always_comb begin
        n_active     = r_active;
        n_start_city = r_start_city;
        n_prev_city  = r_prev_city;
        n_city_first = r_city_first;
        n_city_last  = r_city_last;
        n_city       = r_city;
        if (w_tour_accept) begin
            n_active     = !i_last_city;
            n_prev_city  = i_city_a;
            n_city_first = !r_active;
            n_city_last  = i_last_city;
            n_city       = i_city_a;
            if (!r_active) begin
                n_start_city = i_city_a;
            end
        end
    end

    // Sequencer and accumulator updates.
    always_comb begin
        n_state          = r_state;
        n_arrival        = r_arrival;
        n_sum            = r_sum;
        n_viol           = r_viol;
        o_res_load       = 1'b0;
        o_res_duration   = r_sum;
        o_res_violations = w_chk_viol;
        unique case (r_state)
            twte_pkg::ST_IDLE: begin
                if (w_tour_accept) begin
                    n_state = twte_pkg::ST_ADD;
                end
            end
            twte_pkg::ST_ADD: begin
                if (r_city_first) begin
                    n_arrival = '0;
                    n_sum     = '0;
                    n_viol    = '0;
                end else begin
                    n_arrival = w_leg_arrival;
                    n_sum     = w_leg_sum;
                end
                n_state = twte_pkg::ST_CHECK;
            end
            twte_pkg::ST_CHECK: begin
                n_arrival = w_chk_arrival;
                n_viol    = w_chk_viol;
                if (r_city_last) begin
                    n_state = twte_pkg::ST_RET_ADD;
                end else if (w_tour_accept) begin
                    n_state = twte_pkg::ST_ADD;
                end else begin
                    n_state = twte_pkg::ST_IDLE;
                end
            end
            twte_pkg::ST_RET_ADD: begin
                n_arrival = w_leg_arrival;
                n_sum     = w_leg_sum;
                n_state   = twte_pkg::ST_RET_CHECK;
            end
            twte_pkg::ST_RET_CHECK: begin
                if (i_res_free) begin
                    n_arrival  = w_chk_arrival;
                    n_viol     = w_chk_viol;
                    o_res_load = 1'b1;
                    n_state    = twte_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = twte_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state is reset; the accumulators are cleared by the first city of a tour.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= twte_pkg::ST_IDLE;
            r_active     <= 1'b0;
            r_start_city <= '0;
            r_prev_city  <= '0;
            r_city_first <= 1'b0;
            r_city_last  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_start_city <= n_start_city;
            r_prev_city  <= n_prev_city;
            r_city_first <= n_city_first;
            r_city_last  <= n_city_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_city    <= n_city;
        r_arrival <= n_arrival;
        r_sum     <= n_sum;
        r_viol    <= n_viol;
    end

endmodule

>>> sim/time_window_tour_evaluator_checker.sv
`timescale 1ns / 100ps

module time_window_tour_evaluator_checker #(
    parameter int MAX_CITIES = 256,
    parameter int DIST_BITS  = 16,
    parameter int TIME_BITS  = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [twte_pkg::OP_W-1:0]       i_operation,
    input  logic [twte_pkg::CITY_W-1:0]     i_city_a,
    input  logic [twte_pkg::CITY_W-1:0]     i_city_b,
    input  logic [DIST_BITS-1:0]            i_travel_time,
    input  logic [TIME_BITS-1:0]            i_window_open,
    input  logic [TIME_BITS-1:0]            i_window_close,
    input  logic                            i_last_city,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [twte_pkg::SUM_W-1:0]      i_tour_duration,
    input  logic [twte_pkg::VIOL_W-1:0]     i_violation_count,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int SUM_W  = twte_pkg::SUM_W;
    localparam int VIOL_W = twte_pkg::VIOL_W;
    localparam int CITY_W = twte_pkg::CITY_W;

    typedef struct packed {
        logic [SUM_W-1:0]  duration;
        logic [VIOL_W-1:0] violations;
    } t_tour_score;

    // Shadow copies of the travel table and the city windows.
    logic [DIST_BITS-1:0] leg_time [0:MAX_CITIES*MAX_CITIES-1];
    logic [TIME_BITS-1:0] open_at  [0:MAX_CITIES-1];
    logic [TIME_BITS-1:0] close_at [0:MAX_CITIES-1];

    // Running state of the tour under evaluation.
    logic [SUM_W-1:0]  clock_now;
    logic [SUM_W-1:0]  distance;
    logic [VIOL_W-1:0] late_count;
    logic [CITY_W-1:0] first_city;
    logic [CITY_W-1:0] last_seen;
    logic              tour_open;

    t_tour_score tour_scores_q[$];

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] base,
                                                 input logic [DIST_BITS-1:0] step);
        logic [SUM_W:0] total;
        total = {1'b0, base} + (SUM_W+1)'(step);
        return total[SUM_W] ? twte_pkg::SUM_MAX : total[SUM_W-1:0];
    endfunction

    // One leg adds to both the arrival time and the travel sum.
    function automatic void travel(input logic [CITY_W-1:0] from, input logic [CITY_W-1:0] to);
        logic [DIST_BITS-1:0] step;
        step = leg_time[{from, to}];
        clock_now = sat_sum(clock_now, step);
        distance = sat_sum(distance, step);
    endfunction

    // An early arrival waits for the window to open; a late one is counted.
    function automatic void check_window(input logic [CITY_W-1:0] city);
        if (clock_now < open_at[city]) begin
            clock_now = open_at[city];
        end else if (clock_now > close_at[city]) begin
            if (late_count != twte_pkg::VIOL_MAX) begin
                late_count = late_count + VIOL_W'(1);
            end
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_tour_score want;
        t_tour_score made;
        if (!i_rst_n) begin
            clock_now = '0;
            distance = '0;
            late_count = '0;
            first_city = '0;
            last_seen = '0;
            tour_open = 1'b0;
            tour_scores_q.delete();
        end else begin
            // Compare a result transfer with the oldest predicted score.
            if (i_out_valid && !i_out_stall) begin
                if (tour_scores_q.size() == 0) begin
                    $error("result with no closed tour pending: %s %0d, %s %0d",
                           "tour_duration", i_tour_duration,
                           "violation_count", i_violation_count);
                    o_fail_count++;
                end else begin
                    want = tour_scores_q.pop_front();
                    if (i_tour_duration !== want.duration) begin
                        $error("tour_duration: expected %0d, got %0d", want.duration,
                               i_tour_duration);
                        o_fail_count++;
                    end
                    if (i_violation_count !== want.violations) begin
                        $error("violation_count: expected %0d, got %0d", want.violations,
                               i_violation_count);
                        o_fail_count++;
                    end
                end
            end

            // Apply an input transfer to the shadow state.
            if (i_in_valid && !i_in_stall) begin
                case (i_operation)
                    twte_pkg::OP_TRAVEL: begin
                        leg_time[{i_city_a, i_city_b}] = i_travel_time;
                    end
                    twte_pkg::OP_WINDOW: begin
                        open_at[i_city_a] = i_window_open;
                        close_at[i_city_a] = i_window_close;
                    end
                    twte_pkg::OP_TOUR: begin
                        if (!tour_open) begin
                            clock_now = '0;
                            distance = '0;
                            late_count = '0;
                            first_city = i_city_a;
                            tour_open = 1'b1;
                        end else begin
                            travel(last_seen, i_city_a);
                        end
                        check_window(i_city_a);
                        last_seen = i_city_a;
                        // Closing city: return leg and a second look at the start window.
                        if (i_last_city) begin
                            travel(i_city_a, first_city);
                            check_window(first_city);
                            tour_open = 1'b0;
                            made.duration = distance;
                            made.violations = late_count;
                            tour_scores_q.insert(tour_scores_q.size(), made);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending <= tour_scores_q.size();
    end

endmodule

>>> sim/time_window_tour_evaluator_tb.sv
`timescale 1ns / 100ps

module time_window_tour_evaluator_tb;

    localparam int MAX_CITIES = 256;
    localparam int DIST_BITS  = 16;
    localparam int TIME_BITS  = 24;

    localparam int OP_W   = twte_pkg::OP_W;
    localparam int CITY_W = twte_pkg::CITY_W;
    localparam int SUM_W  = twte_pkg::SUM_W;
    localparam int VIOL_W = twte_pkg::VIOL_W;

    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [DIST_BITS-1:0] DIST_MAX   = '1;
    localparam logic [TIME_BITS-1:0] TIME_MAX   = '1;
    localparam int                   IDLE_LIMIT = 2000;
    localparam int                   LONG_TOUR  = 516;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [OP_W-1:0]        i_operation = '0;
    logic [CITY_W-1:0]      i_city_a = '0;
    logic [CITY_W-1:0]      i_city_b = '0;
    logic [DIST_BITS-1:0]   i_travel_time = '0;
    logic [TIME_BITS-1:0]   i_window_open = '0;
    logic [TIME_BITS-1:0]   i_window_close = '0;
    logic                   i_last_city = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [SUM_W-1:0]       o_tour_duration;
    logic [VIOL_W-1:0]      o_violation_count;

    int fail_count;
    int pending;
    int send_gap_pct = 0;
    int out_stall_pct = 0;
    int items_sent = 0;
    int tours_sent = 0;
    int quiet_cycles = 0;

    // Which table entries hold a value, so that no tour reads an unwritten one.
    bit leg_known [0:MAX_CITIES*MAX_CITIES-1];
    bit window_known [0:MAX_CITIES-1];

    // Stimulus-side view of the tour in progress.
    bit                tour_running = 1'b0;
    logic [CITY_W-1:0] tour_first;
    logic [CITY_W-1:0] tour_prev;
    logic [CITY_W-1:0] pool [0:7];

    time_window_tour_evaluator #(
        .MAX_CITIES (MAX_CITIES),
        .DIST_BITS  (DIST_BITS),
        .TIME_BITS  (TIME_BITS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_city_a          (i_city_a),
        .i_city_b          (i_city_b),
        .i_travel_time     (i_travel_time),
        .i_window_open     (i_window_open),
        .i_window_close    (i_window_close),
        .i_last_city       (i_last_city),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_tour_duration   (o_tour_duration),
        .o_violation_count (o_violation_count)
    );

    time_window_tour_evaluator_checker #(
        .MAX_CITIES (MAX_CITIES),
        .DIST_BITS  (DIST_BITS),
        .TIME_BITS  (TIME_BITS)
    ) tour_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_city_a          (i_city_a),
        .i_city_b          (i_city_b),
        .i_travel_time     (i_travel_time),
        .i_window_open     (i_window_open),
        .i_window_close    (i_window_close),
        .i_last_city       (i_last_city),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_tour_duration   (o_tour_duration),
        .i_violation_count (o_violation_count),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The result side stalls at random.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // Give up when no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("[time_window_tour_evaluator] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One input transfer, preceded by random sender gaps.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CITY_W-1:0] city_a,
                             input logic [CITY_W-1:0] city_b,
                             input logic [DIST_BITS-1:0] leg_len,
                             input logic [TIME_BITS-1:0] w_open,
                             input logic [TIME_BITS-1:0] w_close, input logic last);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_city_a <= city_a;
        i_city_b <= city_b;
        i_travel_time <= leg_len;
        i_window_open <= w_open;
        i_window_close <= w_close;
        i_last_city <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (op != OP_UNUSED) items_sent++;
        if (op == twte_pkg::OP_TOUR && last) tours_sent++;
    endtask

    task automatic load_leg(input logic [CITY_W-1:0] from, input logic [CITY_W-1:0] to,
                            input logic [DIST_BITS-1:0] leg_len);
        send_item(twte_pkg::OP_TRAVEL, from, to, leg_len, TIME_BITS'($urandom),
                  TIME_BITS'($urandom), 1'($urandom));
        leg_known[{from, to}] = 1'b1;
    endtask

    task automatic load_window(input logic [CITY_W-1:0] city, input logic [TIME_BITS-1:0] w_open,
                               input logic [TIME_BITS-1:0] w_close);
        send_item(twte_pkg::OP_WINDOW, city, CITY_W'($urandom), DIST_BITS'($urandom), w_open,
                  w_close, 1'($urandom));
        window_known[city] = 1'b1;
    endtask

    // Mostly short legs, with zero, full-scale and fully random ones mixed in.
    function automatic logic [DIST_BITS-1:0] pick_dist();
        int roll;
        logic [DIST_BITS-1:0] leg_len;
        roll = $urandom_range(0, 99);
        leg_len = DIST_BITS'($urandom);
        if (roll < 10) return '0;
        if (roll < 15) return DIST_MAX;
        if (roll < 30) return leg_len;
        return DIST_BITS'($urandom_range(1, 600));
    endfunction

    // Windows that give early, on-time and late arrivals, plus inverted and random ones.
    function automatic logic [2*TIME_BITS-1:0] pick_window();
        logic [TIME_BITS-1:0] lo;
        logic [TIME_BITS-1:0] hi;
        lo = TIME_BITS'($urandom);
        hi = TIME_BITS'($urandom);
        case ($urandom_range(0, 4))
            0: return {{TIME_BITS{1'b0}}, TIME_MAX};
            1: begin
                lo = TIME_BITS'($urandom_range(0, 3000));
                return {lo, lo + TIME_BITS'($urandom_range(0, 2500))};
            end
            2: return {lo, hi};
            3: return '0;
            default: begin
                lo = TIME_BITS'($urandom_range(0, 20000));
                return {lo, lo + TIME_BITS'($urandom_range(0, 300))};
            end
        endcase
    endfunction

    function automatic logic [CITY_W-1:0] pick_city();
        logic [CITY_W-1:0] any_city;
        any_city = CITY_W'($urandom);
        if ($urandom_range(0, 3) != 0) return pool[3'($urandom_range(0, 7))];
        return any_city;
    endfunction

    task automatic noise_leg();
        load_leg(CITY_W'($urandom), CITY_W'($urandom), pick_dist());
    endtask

    // A tour city; the window and legs it will read are loaded first if still unknown.
    task automatic visit(input logic [CITY_W-1:0] city, input logic last);
        logic [CITY_W-1:0] head;
        logic [2*TIME_BITS-1:0] win;
        head = tour_running ? tour_first : city;
        if (!window_known[city]) begin
            win = pick_window();
            load_window(city, win[2*TIME_BITS-1:TIME_BITS], win[TIME_BITS-1:0]);
        end
        if (tour_running && !leg_known[{tour_prev, city}]) load_leg(tour_prev, city, pick_dist());
        if (last && !leg_known[{city, head}]) load_leg(city, head, pick_dist());
        send_item(twte_pkg::OP_TOUR, city, CITY_W'($urandom), DIST_BITS'($urandom),
                  TIME_BITS'($urandom), TIME_BITS'($urandom), last);
        tour_running = !last;
        tour_first = head;
        tour_prev = city;
    endtask

    // Hold the sender until every predicted score has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic new_phase(input int gap_pct, input int stall_pct);
        drain();
        send_gap_pct = gap_pct;
        out_stall_pct = stall_pct;
        for (int k = 0; k < 8; k++) pool[k] = CITY_W'($urandom);
    endtask

    // Random mix: mostly well-formed tours, with loads and ignored items between.
    task automatic run_mix(input int until_count);
        int roll;
        int len;
        logic [2*TIME_BITS-1:0] win;
        while (items_sent < until_count) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                noise_leg();
            end else if (roll < 16) begin
                win = pick_window();
                load_window(CITY_W'($urandom), win[2*TIME_BITS-1:TIME_BITS],
                            win[TIME_BITS-1:0]);
            end else if (roll < 19) begin
                send_item(OP_UNUSED, CITY_W'($urandom), CITY_W'($urandom),
                          DIST_BITS'($urandom), TIME_BITS'($urandom), TIME_BITS'($urandom),
                          1'($urandom));
            end else begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) noise_leg();
                    visit(pick_city(), k == len - 1);
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [CITY_W-1:0] city_x;
        logic [CITY_W-1:0] city_y;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme windows and legs, an ignored operation, a one-city tour.
        load_window(8'd0, '0, TIME_MAX);
        load_window(8'd255, TIME_MAX, '0);
        load_leg(8'd0, 8'd0, DIST_MAX);
        load_leg(8'd0, 8'd255, DIST_MAX);
        load_leg(8'd255, 8'd0, '0);
        send_item(OP_UNUSED, 8'hFF, 8'hFF, DIST_MAX, TIME_MAX, TIME_MAX, 1'b1);
        visit(8'd0, 1'b1);
        // Early arrival waits at the far city; the return leg costs nothing.
        visit(8'd0, 1'b0);
        visit(8'd255, 1'b1);
        // Starting at the inverted window makes the return check late.
        visit(8'd255, 1'b0);
        visit(8'd0, 1'b1);
        // Alternating bit patterns, waits and late arrivals in one tour.
        load_window(8'hAA, 24'h555555, 24'hAAAAAA);
        load_window(8'h55, 24'hAAAAAA, 24'h555555);
        load_leg(8'hAA, 8'h55, 16'h5A5A);
        load_leg(8'h55, 8'hAA, 16'hA5A5);
        load_leg(8'h55, 8'h55, 16'd1);
        visit(8'hAA, 1'b0);
        visit(8'h55, 1'b0);
        visit(8'h55, 1'b0);
        visit(8'hAA, 1'b1);

        new_phase(8, 55);
        run_mix(150);
        new_phase(55, 8);
        run_mix(260);
        new_phase(0, 0);

        // A long tour between two always-late cities saturates the violation count.
        city_x = CITY_W'($urandom);
        city_y = city_x + CITY_W'(1);
        load_window(city_x, '0, '0);
        load_window(city_y, '0, '0);
        load_leg(city_x, city_y, DIST_BITS'($urandom_range(1, 100)));
        load_leg(city_y, city_x, DIST_BITS'($urandom_range(1, 100)));
        for (int k = 0; k < LONG_TOUR; k++) begin
            visit(k[0] ? city_y : city_x, k == LONG_TOUR - 1);
        end

        run_mix(850);
        drain();
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d load and tour items and %0d closed tours, including one that",
                 items_sent, tours_sent);
        $display("saturates the violation count, under three mixes of sender gaps and stalls.");
        if (fail_count == 0 && pending == 0) begin
            $display("[time_window_tour_evaluator] OK");
        end else begin
            $display("[time_window_tour_evaluator] ERROR");
        end
        $finish;
    end

endmodule
